// ===== rtl/indexed_doubly_linked_list_table_unit_assert.svh =====
// Assertion macros used by the checker of the linked list table unit.
// No dependencies; the including scope must provide clk and rst_n.
`ifndef INDEXED_DOUBLY_LINKED_LIST_TABLE_UNIT_ASSERT_SVH
`define INDEXED_DOUBLY_LINKED_LIST_TABLE_UNIT_ASSERT_SVH

// Checked at every rising edge outside reset.
`define IDLT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define IDLT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/idlt_pkg.sv =====
// Shared types and constants of the linked list table unit.
// No dependencies.
package idlt_pkg;

    localparam int CMD_W      = 4;
    localparam int FIELD_IDX_W = 10;
    localparam int TAG_W      = 16;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [CMD_W-1:0] {
        CMD_INIT       = 4'd0,
        CMD_ADD_HEAD   = 4'd1,
        CMD_ADD_TAIL   = 4'd2,
        CMD_DELETE     = 4'd3,
        CMD_IS_EMPTY   = 4'd4,
        CMD_GET_TAG    = 4'd5,
        CMD_SET_TAG    = 4'd6,
        CMD_SET_FLAG   = 4'd7,
        CMD_CLEAR_FLAG = 4'd8
    } cmd_t;

endpackage

// ===== rtl/idlt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module idlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/indexed_doubly_linked_list_table_unit.sv =====
// Top level of the indexed circular doubly linked list table.
// Depends on idlt_pkg and idlt_ram.
//
//  Channel   Direction  Beat carries
//  --------  ---------  ---------------------------------------------------
//  s_axis    in         one command: cmd, node_index, head_index, tag_value
//  m_axis    out        one result per command: flag_result, tag_result
//
// Init writes the node in place; unknown codes give a zero result and touch
// no memory; the empty test and the tag and flag commands read once; the list
// commands (insert after, insert before, unlink) make three reads in turn
// through the single read port of the link memory, then three writes.
// Reset clears the sequencer and the output valid flag only; the memories hold
// garbage until init writes a node. A stalled result waits in the output
// register while the next command is taken; that command then waits in its
// final state until the register frees.
module indexed_doubly_linked_list_table_unit
    import idlt_pkg::*;
#(
    parameter int NODE_COUNT = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [3:0] cmd, [13:4] node_index, [23:14] head_index, [39:24] tag_value
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] flag_result, [16:1] tag_result, [23:17] zero
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W       = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int LINK_W      = 2 * IDX_W;
    localparam int DATA_W      = TAG_W + 1;
    localparam int RECIP_SHIFT = 20;
    // Reciprocal rounded down: the estimated quotient is exact or one short,
    // so one compare and subtract finishes the reduction.
    localparam logic [31:0] RECIP = 32'((64'd1 << RECIP_SHIFT) / NODE_COUNT);
    localparam logic [31:0] COUNT = 32'(NODE_COUNT);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_FOLD = 8'b0000_0010,
        S_RD0  = 8'b0000_0100,
        S_RD1  = 8'b0000_1000,
        S_RD2  = 8'b0001_0000,
        S_W1   = 8'b0010_0000,
        S_W2   = 8'b0100_0000,
        S_W3   = 8'b1000_0000
    } state_t;

    // Final state kept separate from the one-hot list above would cost a bit;
    // the result hand-off is held in a flag instead.
    state_t state_reg, state_next;
    logic   done_reg, done_next;
    logic   m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;

    // Command payload
    cmd_t                   cmd_reg, cmd_next;
    logic [FIELD_IDX_W-1:0] node_raw_reg, node_raw_next;
    logic [FIELD_IDX_W-1:0] head_raw_reg, head_raw_next;
    logic [FIELD_IDX_W-1:0] node_q_reg, node_q_next;
    logic [FIELD_IDX_W-1:0] head_q_reg, head_q_next;
    logic [TAG_W-1:0]       tag_in_reg, tag_in_next;
    logic [IDX_W-1:0]       n_reg, n_next;
    logic [IDX_W-1:0]       h_reg, h_next;
    logic [LINK_W-1:0]      x0_reg, x0_next;
    logic [LINK_W-1:0]      ea_reg, ea_next;
    logic [LINK_W-1:0]      eb_reg, eb_next;
    logic                   res_flag_reg, res_flag_next;
    logic [TAG_W-1:0]       res_tag_reg, res_tag_next;

    // Memory ports
    logic              link_we;
    logic [IDX_W-1:0]  link_waddr, link_raddr;
    logic [LINK_W-1:0] link_wdata, link_rdata;
    logic              data_we;
    logic [IDX_W-1:0]  data_waddr, data_raddr;
    logic [DATA_W-1:0] data_wdata, data_rdata;

    logic [IDX_W-1:0] a_idx, b_idx, a_live;
    logic [IDX_W-1:0] pa, na, nb, ph, nh;

    // Remainder step of the index reduction; the quotient estimate is
    // registered at acceptance so only one multiplier sits in this path.
    function automatic logic [IDX_W-1:0] fold_fix(
        input logic [FIELD_IDX_W-1:0] raw,
        input logic [FIELD_IDX_W-1:0] q
    );
        logic [31:0] rem;
        rem = 32'(raw) - (32'(q) * COUNT);
        if (rem >= COUNT)
        begin
            rem = rem - COUNT;
        end
        return rem[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] prev_of(input logic [LINK_W-1:0] e);
        return e[LINK_W-1 -: IDX_W];
    endfunction

    function automatic logic [IDX_W-1:0] next_of(input logic [LINK_W-1:0] e);
        return e[IDX_W-1:0];
    endfunction

    // Link entries pack as {prev, next}; node data as {tag, flag}.
    idlt_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NODE_COUNT)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    idlt_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NODE_COUNT)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .raddr (data_raddr),
        .rdata (data_rdata)
    );

    assign s_tready = (state_reg == S_IDLE) && !done_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // The neighbour: after the head for insert-after, before the head for insert-before, before the node for unlink.
    assign a_idx = (cmd_reg == CMD_ADD_HEAD) ? next_of(x0_reg) : prev_of(x0_reg);
    assign a_live = (cmd_reg == CMD_ADD_HEAD) ? next_of(link_rdata) : prev_of(link_rdata);
    assign b_idx = next_of(x0_reg);
    assign ph    = prev_of(x0_reg);
    assign nh    = next_of(x0_reg);
    assign pa    = prev_of(ea_reg);
    assign na    = next_of(ea_reg);
    assign nb    = next_of(eb_reg);

    always_comb
    begin
        state_next    = state_reg;
        done_next     = done_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        cmd_next      = cmd_reg;
        node_raw_next = node_raw_reg;
        head_raw_next = head_raw_reg;
        node_q_next   = node_q_reg;
        head_q_next   = head_q_reg;
        tag_in_next   = tag_in_reg;
        n_next        = n_reg;
        h_next        = h_reg;
        x0_next       = x0_reg;
        ea_next       = ea_reg;
        eb_next       = eb_reg;
        res_flag_next = res_flag_reg;
        res_tag_next  = res_tag_reg;

        link_we    = 1'b0;
        link_waddr = n_reg;
        link_wdata = {n_reg, n_reg};
        link_raddr = n_reg;
        data_we    = 1'b0;
        data_waddr = n_reg;
        data_wdata = '0;
        data_raddr = n_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (done_reg)
                begin
                    if (!m_valid_reg || m_tready)
                    begin
                        m_valid_next = 1'b1;
                        m_data_next  = {(OUT_TDATA_W - DATA_W)'(0), res_tag_reg, res_flag_reg};
                        done_next    = 1'b0;
                    end
                end
                else if (s_tvalid)
                begin
                    cmd_next      = cmd_t'(s_tdata[3:0]);
                    node_raw_next = s_tdata[13:4];
                    head_raw_next = s_tdata[23:14];
                    tag_in_next   = s_tdata[39:24];
                    node_q_next   = FIELD_IDX_W'((32'(s_tdata[13:4]) * RECIP) >> RECIP_SHIFT);
                    head_q_next   = FIELD_IDX_W'((32'(s_tdata[23:14]) * RECIP) >> RECIP_SHIFT);
                    state_next    = S_FOLD;
                end
            end
            S_FOLD:
            begin
                n_next        = fold_fix(node_raw_reg, node_q_reg);
                h_next        = fold_fix(head_raw_reg, head_q_reg);
                res_flag_next = 1'b0;
                res_tag_next  = '0;
                case (cmd_reg)
                    CMD_INIT:
                    begin
                        state_next = S_W1;
                    end
                    CMD_ADD_HEAD, CMD_ADD_TAIL, CMD_DELETE, CMD_IS_EMPTY,
                    CMD_GET_TAG, CMD_SET_TAG, CMD_SET_FLAG, CMD_CLEAR_FLAG:
                    begin
                        state_next = S_RD0;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                    end
                endcase
            end
            S_RD0:
            begin
                link_raddr = (cmd_reg == CMD_DELETE) ? n_reg : h_reg;
                state_next = S_RD1;
            end
            S_RD1:
            begin
                x0_next    = link_rdata;
                link_raddr = a_live;
                state_next = S_IDLE;
                done_next  = 1'b1;
                case (cmd_reg)
                    CMD_ADD_HEAD, CMD_ADD_TAIL, CMD_DELETE:
                    begin
                        state_next = S_RD2;
                        done_next  = 1'b0;
                    end
                    CMD_IS_EMPTY:
                    begin
                        res_flag_next = (prev_of(link_rdata) == h_reg)
                                     && (next_of(link_rdata) == h_reg);
                    end
                    CMD_GET_TAG:
                    begin
                        res_tag_next = data_rdata[DATA_W-1:1];
                    end
                    CMD_SET_TAG:
                    begin
                        data_we    = 1'b1;
                        data_wdata = {tag_in_reg, data_rdata[0]};
                    end
                    CMD_SET_FLAG:
                    begin
                        data_we       = 1'b1;
                        data_wdata    = {data_rdata[DATA_W-1:1], 1'b1};
                        res_flag_next = !data_rdata[0];
                    end
                    CMD_CLEAR_FLAG:
                    begin
                        data_we       = 1'b1;
                        data_wdata    = {data_rdata[DATA_W-1:1], 1'b0};
                        res_flag_next = data_rdata[0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_RD2:
            begin
                ea_next    = link_rdata;
                link_raddr = b_idx;
                state_next = S_W1;
            end
            S_W1:
            begin
                // The node itself is always rewritten first and in full.
                eb_next    = link_rdata;
                link_we    = 1'b1;
                link_waddr = n_reg;
                state_next = S_W2;
                case (cmd_reg)
                    CMD_ADD_HEAD:
                    begin
                        link_wdata = {h_reg, a_idx};
                    end
                    CMD_ADD_TAIL:
                    begin
                        link_wdata = {a_idx, h_reg};
                    end
                    default:
                    begin
                        link_wdata = {n_reg, n_reg};
                    end
                endcase
                if (cmd_reg == CMD_INIT)
                begin
                    data_we    = 1'b1;
                    data_wdata = '0;
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end
            S_W2:
            begin
                // Each later write keeps the other half as the earlier writes
                // left it, so aliased indices end as in sequential code.
                link_we    = 1'b1;
                state_next = S_W3;
                case (cmd_reg)
                    CMD_ADD_HEAD:
                    begin
                        link_waddr = h_reg;
                        link_wdata = {(h_reg == n_reg) ? h_reg : ph, n_reg};
                    end
                    CMD_ADD_TAIL:
                    begin
                        link_waddr = h_reg;
                        link_wdata = {n_reg, (h_reg == n_reg) ? h_reg : nh};
                    end
                    default:
                    begin
                        link_waddr = a_idx;
                        link_wdata = {(a_idx == n_reg) ? n_reg : pa, b_idx};
                    end
                endcase
            end
            S_W3:
            begin
                link_we    = 1'b1;
                state_next = S_IDLE;
                done_next  = 1'b1;
                case (cmd_reg)
                    CMD_ADD_HEAD:
                    begin
                        link_waddr = a_idx;
                        link_wdata = {n_reg, (a_idx == h_reg) ? n_reg :
                                             (a_idx == n_reg) ? a_idx : na};
                    end
                    CMD_ADD_TAIL:
                    begin
                        link_waddr = a_idx;
                        link_wdata = {(a_idx == h_reg) ? n_reg :
                                      (a_idx == n_reg) ? a_idx : pa, n_reg};
                    end
                    default:
                    begin
                        link_waddr = b_idx;
                        link_wdata = {a_idx, (b_idx == a_idx) ? b_idx :
                                             (b_idx == n_reg) ? n_reg : nb};
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            done_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            done_reg    <= done_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg   <= m_data_next;
        cmd_reg      <= cmd_next;
        node_raw_reg <= node_raw_next;
        head_raw_reg <= head_raw_next;
        node_q_reg   <= node_q_next;
        head_q_reg   <= head_q_next;
        tag_in_reg   <= tag_in_next;
        n_reg        <= n_next;
        h_reg        <= h_next;
        x0_reg       <= x0_next;
        ea_reg       <= ea_next;
        eb_reg       <= eb_next;
        res_flag_reg <= res_flag_next;
        res_tag_reg  <= res_tag_next;
    end

endmodule

// ===== rtl/idlt_checker.sv =====
// Port-level checker for the linked list table unit, bound to its top level.
// Depends on idlt_pkg and indexed_doubly_linked_list_table_unit_assert.svh.
`include "indexed_doubly_linked_list_table_unit_assert.svh"

module idlt_checker
    import idlt_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [IN_TDATA_W-1:0]  s_tdata,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    logic [1:0] pending_reg, pending_next;
    logic       in_beat, out_beat;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    always_comb
    begin
        pending_next = pending_reg + 2'(in_beat) - 2'(out_beat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `IDLT_ASSERT(a_result_held, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result beat changed while stalled")
    `IDLT_ASSERT(a_one_at_a_time, in_beat |=> !s_tready ##1 !s_tready, "command taken while another is in work")
    `IDLT_ASSERT(a_no_invented, pending_reg != 2'd3 && (!m_tvalid || pending_reg != 2'd0), "result count does not match commands")
    `IDLT_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !m_tvalid, "result shown during reset")

endmodule

bind indexed_doubly_linked_list_table_unit idlt_checker u_idlt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== bench/tb_indexed_doubly_linked_list_table_unit.sv =====
// Self-checking testbench for the indexed circular doubly linked list table unit.
// Depends on idlt_pkg and the RTL top level; a scoreboard class predicts every result.
module tb_indexed_doubly_linked_list_table_unit;
    import idlt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH    = 1024;
    localparam int RANDOM_ITEMS   = 925;
    // Cycles without any accepted beat before the run is declared hung. The
    // slowest correct gap is the long receiver hold-off plus a few commands.
    localparam int STALL_LIMIT    = 4000;
    // The one long hold-off of the receiver, and the result that triggers it.
    localparam int HOLD_OFF_BEATS = 400;
    localparam int HOLD_OFF_AT    = 300;
    localparam int DRAIN_CYCLES   = 20;

    typedef logic [FIELD_IDX_W-1:0] idx_t;

    // Mirror of the node table. It predicts one result per accepted command
    // and keeps those results in order until the block delivers them.
    class list_table_scoreboard;
        typedef struct packed {
            logic             flag;
            logic [TAG_W-1:0] tag;
        } result_t;

        idx_t             prev_link [TABLE_DEPTH];
        idx_t             next_link [TABLE_DEPTH];
        logic [TAG_W-1:0] node_tag  [TABLE_DEPTH];
        logic             node_flag [TABLE_DEPTH];
        bit               written   [TABLE_DEPTH];
        // Nodes that an init has written; only these may ever be read.
        idx_t             live_nodes[$];
        result_t          pending_results[$];
        int unsigned      failures;

        function new();
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                prev_link[i] = '0;
                next_link[i] = '0;
                node_tag[i]  = '0;
                node_flag[i] = 1'b0;
                written[i]   = 1'b0;
            end
            failures = 0;
        endfunction

        function bit is_detached(idx_t n);
            return prev_link[n] == n && next_link[n] == n;
        endfunction

        // Writes go node, head, neighbour (inserts) or node, prev, next (unlink),
        // so that aliased indices end up exactly as the later write leaves them.
        function void note_command(logic [CMD_W-1:0] code, idx_t n, idx_t h,
                                   logic [TAG_W-1:0] tag);
            idx_t    a;
            idx_t    b;
            result_t r;
            r = '0;
            case (code)
                CMD_INIT:
                begin
                    prev_link[n] = n;
                    next_link[n] = n;
                    node_tag[n]  = '0;
                    node_flag[n] = 1'b0;
                    if (!written[n])
                    begin
                        written[n] = 1'b1;
                        live_nodes.push_back(n);
                    end
                end
                CMD_ADD_HEAD:
                begin
                    a = next_link[h];
                    prev_link[n] = h;
                    next_link[n] = a;
                    next_link[h] = n;
                    prev_link[a] = n;
                end
                CMD_ADD_TAIL:
                begin
                    a = prev_link[h];
                    prev_link[n] = a;
                    next_link[n] = h;
                    prev_link[h] = n;
                    next_link[a] = n;
                end
                CMD_DELETE:
                begin
                    a = prev_link[n];
                    b = next_link[n];
                    prev_link[n] = n;
                    next_link[n] = n;
                    next_link[a] = b;
                    prev_link[b] = a;
                end
                CMD_IS_EMPTY:   r.flag = is_detached(h);
                CMD_GET_TAG:    r.tag = node_tag[n];
                CMD_SET_TAG:    node_tag[n] = tag;
                CMD_SET_FLAG:
                begin
                    r.flag = ~node_flag[n];
                    node_flag[n] = 1'b1;
                end
                CMD_CLEAR_FLAG:
                begin
                    r.flag = node_flag[n];
                    node_flag[n] = 1'b0;
                end
                default: ;
            endcase
            pending_results.push_back(r);
        endfunction

        function void report(string what, int unsigned want, int unsigned got);
            failures++;
            if (failures <= 10)
                $display("mismatch on %s: expected 0x%0h, got 0x%0h", what, want, got);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] beat);
            result_t want;
            if (pending_results.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("result beat 0x%0h arrived with no command outstanding", beat);
                return;
            end
            want = pending_results.pop_front();
            if (beat[0] !== want.flag)
                report("flag_result", 32'(want.flag), 32'(beat[0]));
            if (beat[TAG_W:1] !== want.tag)
                report("tag_result", 32'(want.tag), 32'(beat[TAG_W:1]));
            if (beat[OUT_TDATA_W-1:TAG_W+1] !== '0)
                report("padding", 0, 32'(beat[OUT_TDATA_W-1:TAG_W+1]));
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    list_table_scoreboard sb;
    // While calm, a side takes no gaps at all, so that back-to-back beats
    // occur as well as gaps landing on every phase of the block's work.
    bit          sender_calm;
    bit          receiver_calm;
    int unsigned results_seen;

    indexed_doubly_linked_list_table_unit #(
        .NODE_COUNT(TABLE_DEPTH)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #1 clk = ~clk;

    // Offers one command after a random gap and notes it once accepted. It is
    // entered at a falling edge and returns at the falling edge after the
    // handshake, so tvalid stays high across back-to-back beats.
    task automatic send_command(input logic [CMD_W-1:0] code, input idx_t n,
                                input idx_t h, input logic [TAG_W-1:0] tag);
        int unsigned gap;
        gap = sender_calm ? 0 : $urandom_range(0, 19);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {tag, h, n, code};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_command(code, n, h, tag);
        @(negedge clk);
    endtask

    function automatic idx_t pick_live();
        return sb.live_nodes[$urandom_range(0, sb.live_nodes.size() - 1)];
    endfunction

    // Heads come mostly from a few early nodes, so that lists grow long.
    function automatic idx_t pick_head();
        int unsigned span;
        span = (sb.live_nodes.size() < 6) ? sb.live_nodes.size() : 6;
        if ($urandom_range(0, 9) < 6)
            return sb.live_nodes[$urandom_range(0, span - 1)];
        return pick_live();
    endfunction

    // Well-formed inserts take a detached node; when none turns up the last
    // pick is used anyway, which inserts a node that is already linked.
    function automatic idx_t pick_detached();
        idx_t n;
        n = pick_live();
        for (int i = 0; i < 8 && !sb.is_detached(n); i++)
            n = pick_live();
        return n;
    endfunction

    task automatic send_random_command();
        int unsigned      roll;
        logic [CMD_W-1:0] code;
        idx_t             n;
        idx_t             h;
        logic [TAG_W-1:0] tag;
        roll = $urandom_range(0, 99);
        tag  = TAG_W'($urandom);
        n    = pick_live();
        h    = pick_head();
        if (roll < 12)
        begin
            code = CMD_INIT;
            n = ($urandom_range(0, 3) == 0) ? pick_live() : idx_t'($urandom_range(0, 1023));
            h = idx_t'($urandom);
        end
        else if (roll < 25)
        begin
            code = CMD_ADD_HEAD;
            n = pick_detached();
        end
        else if (roll < 38)
        begin
            code = CMD_ADD_TAIL;
            n = pick_detached();
        end
        else if (roll < 50)
        begin
            // The head operand of an unlink is ignored, so it is pure noise.
            code = CMD_DELETE;
            h = idx_t'($urandom);
        end
        else if (roll < 60)
            code = CMD_IS_EMPTY;
        else if (roll < 67)
            code = CMD_GET_TAG;
        else if (roll < 75)
            code = CMD_SET_TAG;
        else if (roll < 85)
            code = CMD_SET_FLAG;
        else if (roll < 95)
            code = CMD_CLEAR_FLAG;
        else
        begin
            // Unused codes touch nothing, so any indices are allowed.
            code = CMD_W'($urandom_range(9, 15));
            n = idx_t'($urandom);
            h = idx_t'($urandom);
        end
        send_command(code, n, h, tag);
    endtask

    // Accepts results after random gaps; once in the run it holds off long
    // enough for the block to fill up and refuse further commands.
    task automatic drain_results();
        int unsigned gap;
        forever
        begin
            if (results_seen % 64 == 0)
                receiver_calm = ($urandom_range(0, 2) == 0);
            gap = receiver_calm ? 0 : $urandom_range(0, 19);
            if (results_seen == HOLD_OFF_AT)
                gap = HOLD_OFF_BEATS;
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            sb.check_result(m_tdata);
            results_seen++;
            @(negedge clk);
        end
    endtask

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        sender_calm   = 1'b0;
        receiver_calm = 1'b0;
        results_seen  = 0;
        sb = new();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        fork
            drain_results();
        join_none

        // Directed part: table edges, every command, aliased operands,
        // unlinking a head and a lone node, and the unused codes.
        send_command(CMD_INIT,       10'd0,    10'd1023, 16'hFFFF);
        send_command(CMD_INIT,       10'd1023, 10'd0,    16'h0000);
        send_command(CMD_INIT,       10'd1,    10'd512,  16'h1234);
        send_command(CMD_INIT,       10'd512,  10'd1,    16'h8001);
        send_command(CMD_IS_EMPTY,   10'd1023, 10'd0,    16'h0000);
        send_command(CMD_ADD_HEAD,   10'd1023, 10'd0,    16'hFFFF);
        send_command(CMD_ADD_TAIL,   10'd1,    10'd0,    16'h0000);
        send_command(CMD_ADD_HEAD,   10'd512,  10'd1023, 16'h00FF);
        send_command(CMD_IS_EMPTY,   10'd0,    10'd0,    16'hFF00);
        send_command(CMD_SET_TAG,    10'd1023, 10'd0,    16'hFFFF);
        send_command(CMD_SET_TAG,    10'd1,    10'd0,    16'h5AA5);
        send_command(CMD_GET_TAG,    10'd1023, 10'd1023, 16'h0000);
        send_command(CMD_GET_TAG,    10'd1,    10'd0,    16'hFFFF);
        send_command(CMD_SET_FLAG,   10'd512,  10'd0,    16'h0000);
        send_command(CMD_SET_FLAG,   10'd512,  10'd0,    16'h0000);
        send_command(CMD_CLEAR_FLAG, 10'd512,  10'd0,    16'h0000);
        send_command(CMD_CLEAR_FLAG, 10'd512,  10'd0,    16'h0000);
        send_command(CMD_DELETE,     10'd1023, 10'd777,  16'hA5A5);
        send_command(CMD_DELETE,     10'd0,    10'd1023, 16'h0000);
        send_command(CMD_DELETE,     10'd0,    10'd0,    16'h0000);
        send_command(CMD_ADD_HEAD,   10'd1,    10'd1,    16'h0000);
        send_command(CMD_ADD_TAIL,   10'd512,  10'd512,  16'h0000);
        send_command(CMD_W'(9),      10'd1023, 10'd1023, 16'hFFFF);
        send_command(CMD_W'(15),     10'd0,    10'd0,    16'h0000);
        send_command(CMD_INIT,       10'd1,    10'd0,    16'h0000);
        send_command(CMD_GET_TAG,    10'd1,    10'd0,    16'h0000);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 64 == 0)
                sender_calm = ($urandom_range(0, 2) == 0);
            send_random_command();
        end
        s_tvalid <= 1'b0;

        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.failures == 0 && sb.pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
